// ----- hdl/kdh_pkg.sv -----
// Package with the shared types and constants of the key debounce and hold detector.
`timescale 1ns / 1ps
package kdh_pkg;

  localparam int unsigned KEY_W     = 2;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [CNT_W-1:0] SHAKE_RESET = 16'd5;
  localparam logic [CNT_W-1:0] HOLD_RESET  = 16'd100;
  localparam logic [CNT_W-1:0] CNT_MAX     = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHAKE = 2'd0,
    CFG_HOLD  = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EV_IDLE     = 2'd0,
    EV_PRESSED  = 2'd1,
    EV_RELEASED = 2'd2,
    EV_HELD     = 2'd3
  } key_event_e;

  typedef enum logic [2:0] {
    ST_RELEASED = 3'b001,
    ST_PRESSED  = 3'b010,
    ST_HELD     = 3'b100
  } key_state_e;

endpackage

// ----- hdl/kdh_sample_if.sv -----
// Valid/ready channel interfaces for key samples and key events.
`timescale 1ns / 1ps
interface kdh_sample_if;
  logic                     valid;
  logic                     ready;
  logic [kdh_pkg::KEY_W-1:0] key_index;
  logic                     pin_level;

  modport source (output valid, output key_index, output pin_level, input ready);
  modport sink (input valid, input key_index, input pin_level, output ready);
endinterface

interface kdh_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;

  modport source (output valid, output event_res, input ready);
  modport sink (input valid, input event_res, output ready);
endinterface

// ----- hdl/key_debounce_hold_detect_unit.sv -----
// Key debounce and long-press detector for up to NUM_KEYS keys.
//
// The sample_i channel carries one raw sample of one key per transfer: a key
// index and the pin level, which is active low. The evt_o channel returns one
// event code per sample: idle, pressed, released or held. A key index at or
// above NUM_KEYS gives idle and leaves all key state untouched.
// The configuration port sets the debounce length (index 0) and the hold
// length (index 1); write it only while no sample is in flight.
// A sample passes an input register, then the counter compare and state
// update of its key, then the result register. One sample is taken every
// cycle while the receiver takes events, also for the same key back to
// back, since the key state is written at the same edge at which the next
// sample enters the input register.
// When the receiver stalls, the result register holds its event and the
// input register takes at most one more sample before sample_i.ready drops.
// Reset releases every key, clears all counters and loads a debounce length
// of 5 and a hold length of 100.
`timescale 1ns / 1ps
module key_debounce_hold_detect_unit #(
  parameter int unsigned NUM_KEYS = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [kdh_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kdh_pkg::CFG_DAT_W-1:0]  cfg_wdata_i,
  kdh_sample_if.sink                     sample_i,
  kdh_event_if.source                    evt_o
);
  import kdh_pkg::*;

  logic [CNT_W-1:0] shake_cnt_q;
  logic [CNT_W-1:0] hold_cnt_q;

  logic             in_vld_q;
  logic [KEY_W-1:0] key_q;
  logic             pin_q;
  logic             out_vld_q;
  key_event_e       ev_q;

  key_state_e       st_q  [NUM_KEYS];
  logic [CNT_W-1:0] on_q  [NUM_KEYS];
  logic [CNT_W-1:0] off_q [NUM_KEYS];

  logic             fire;
  logic             key_ok;
  logic             active;
  key_state_e       cur_st, st_d;
  logic [CNT_W-1:0] cur_on, cur_off, on_inc, off_inc, on_d, off_d;
  key_event_e       ev_d;

  assign fire            = in_vld_q && (!out_vld_q || evt_o.ready);
  assign sample_i.ready  = !in_vld_q || fire;
  assign evt_o.valid     = out_vld_q;
  assign evt_o.event_res = ev_q;

  assign key_ok = (int'(key_q) < NUM_KEYS);
  assign active = !pin_q;

  always_comb begin
    cur_st  = ST_RELEASED;
    cur_on  = '0;
    cur_off = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (int'(key_q) == k) begin
        cur_st  = st_q[k];
        cur_on  = on_q[k];
        cur_off = off_q[k];
      end
    end
  end

  assign on_inc  = (cur_on == CNT_MAX) ? cur_on : cur_on + 1'b1;
  assign off_inc = (cur_off == CNT_MAX) ? cur_off : cur_off + 1'b1;

  always_comb begin
    st_d  = cur_st;
    on_d  = cur_on;
    off_d = cur_off;
    ev_d  = EV_IDLE;
    unique case (cur_st)
      ST_PRESSED, ST_HELD: begin
        if (active) begin
          off_d = '0;
          if (cur_st == ST_HELD) begin
            ev_d = EV_HELD;
          end else begin
            on_d = on_inc;
            if (on_inc >= hold_cnt_q) begin
              on_d = '0;
              st_d = ST_HELD;
              ev_d = EV_HELD;
            end
          end
        end else begin
          off_d = off_inc;
          if (off_inc >= shake_cnt_q) begin
            st_d  = ST_RELEASED;
            off_d = '0;
            on_d  = '0;
            ev_d  = EV_RELEASED;
          end
        end
      end
      default: begin
        st_d = ST_RELEASED;
        if (active) begin
          on_d = on_inc;
          if (on_inc >= shake_cnt_q) begin
            st_d = ST_PRESSED;
            on_d = '0;
            ev_d = EV_PRESSED;
          end
        end else begin
          on_d = '0;
        end
      end
    endcase
    if (!key_ok) begin
      ev_d = EV_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shake_cnt_q <= SHAKE_RESET;
      hold_cnt_q  <= HOLD_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SHAKE) begin
        shake_cnt_q <= cfg_wdata_i;
      end else if (cfg_idx_i == CFG_HOLD) begin
        hold_cnt_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (sample_i.ready) begin
        in_vld_q <= sample_i.valid;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (evt_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.ready && sample_i.valid) begin
      key_q <= sample_i.key_index;
      pin_q <= sample_i.pin_level;
    end
    if (fire) begin
      ev_q <= ev_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        st_q[k]  <= ST_RELEASED;
        on_q[k]  <= '0;
        off_q[k] <= '0;
      end
    end else if (fire && key_ok) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (int'(key_q) == k) begin
          st_q[k]  <= st_d;
          on_q[k]  <= on_d;
          off_q[k] <= off_d;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("processed sample did not load the result register");

  a_bad_key_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !key_ok) |=> (ev_q == EV_IDLE))
    else $error("invalid key index gave an event other than idle");

  a_input_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !fire) |=> (in_vld_q && $stable(key_q) && $stable(pin_q)))
    else $error("waiting sample was lost or changed");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q[0]))
    else $error("key state left its one-hot encoding");

  a_pressed_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && key_ok && (ev_d == EV_PRESSED || ev_d == EV_HELD)) |-> !pin_q)
    else $error("press or hold reported for an inactive sample");
`endif

endmodule

// ----- sim/kdh_event_monitor.sv -----
// Event monitor: predicts the event of every key sample and compares it with the block's output.
`timescale 1ns / 1ps
module kdh_event_monitor #(
  parameter int unsigned NUM_KEYS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kdh_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [kdh_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  kdh_sample_if                         sample_i,
  kdh_event_if                          evt_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   checked_o,
  output int unsigned                   pressed_o,
  output int unsigned                   released_o,
  output int unsigned                   held_o
);
  import kdh_pkg::*;

  localparam int unsigned MaxReports = 10;

  key_state_e       key_mode [NUM_KEYS];
  logic [CNT_W-1:0] on_cnt [NUM_KEYS];
  logic [CNT_W-1:0] off_cnt [NUM_KEYS];
  logic [CNT_W-1:0] shake_len;
  logic [CNT_W-1:0] hold_len;
  key_event_e       event_fifo [$];
  key_event_e       want;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
    pressed_o    = 0;
    released_o   = 0;
    held_o       = 0;
  end

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // A register value of zero behaves like one.
  function automatic logic [CNT_W-1:0] threshold(input logic [CNT_W-1:0] v);
    return (v == '0) ? CNT_W'(1) : v;
  endfunction

  function automatic key_event_e predict_event(input int unsigned key, input logic pin);
    key_event_e ev;
    logic       active;
    ev     = EV_IDLE;
    active = ~pin;
    if (key < NUM_KEYS) begin
      case (key_mode[key])
        ST_PRESSED, ST_HELD: begin
          if (active) begin
            off_cnt[key] = '0;
            if (key_mode[key] == ST_HELD) begin
              ev = EV_HELD;
            end else begin
              on_cnt[key] = bump(on_cnt[key]);
              if (on_cnt[key] >= threshold(hold_len)) begin
                on_cnt[key]   = '0;
                key_mode[key] = ST_HELD;
                ev            = EV_HELD;
              end
            end
          end else begin
            off_cnt[key] = bump(off_cnt[key]);
            if (off_cnt[key] >= threshold(shake_len)) begin
              key_mode[key] = ST_RELEASED;
              off_cnt[key]  = '0;
              on_cnt[key]   = '0;
              ev            = EV_RELEASED;
            end
          end
        end
        default: begin
          key_mode[key] = ST_RELEASED;
          if (active) begin
            on_cnt[key] = bump(on_cnt[key]);
            if (on_cnt[key] >= threshold(shake_len)) begin
              key_mode[key] = ST_PRESSED;
              on_cnt[key]   = '0;
              ev            = EV_PRESSED;
            end
          end else begin
            on_cnt[key] = '0;
          end
        end
      endcase
    end
    return ev;
  endfunction

  task automatic report_mismatch(input string detail);
    if (fail_count_o < MaxReports) begin
      $display("%0t ns: %s", $time, detail);
    end
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_fifo.delete();
      for (int k = 0; k < NUM_KEYS; k++) begin
        key_mode[k] = ST_RELEASED;
        on_cnt[k]   = '0;
        off_cnt[k]  = '0;
      end
      shake_len = SHAKE_RESET;
      hold_len  = HOLD_RESET;
      pending_o = 0;
    end else begin
      if (evt_i.valid && evt_i.ready) begin
        case (evt_i.event_res)
          EV_PRESSED:  pressed_o++;
          EV_RELEASED: released_o++;
          EV_HELD:     held_o++;
          default: ;
        endcase
        if (event_fifo.size() == 0) begin
          report_mismatch($sformatf("event %0d with no sample outstanding", evt_i.event_res));
        end else begin
          want = event_fifo.pop_front();
          checked_o++;
          if (evt_i.event_res !== want) begin
            report_mismatch($sformatf("event_res expected %0d, got %0d", want,
                                      evt_i.event_res));
          end
        end
      end
      if (sample_i.valid && sample_i.ready) begin
        event_fifo.push_back(predict_event(sample_i.key_index, sample_i.pin_level));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SHAKE: shake_len = cfg_wdata_i;
          CFG_HOLD:  hold_len  = cfg_wdata_i;
          default: ;
        endcase
      end
      pending_o = event_fifo.size();
    end
  end

endmodule

// ----- sim/testbench.sv -----
// Testbench top for the key debounce and hold detector: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import kdh_pkg::*;

  localparam int unsigned NumKeys       = 4;
  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned HoldOffCycles = 300;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata_i = '0;

  kdh_sample_if sample_ch ();
  kdh_event_if  event_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned n_pressed;
  int unsigned n_released;
  int unsigned n_held;
  int unsigned src_gap_pct  = 0;
  int unsigned sink_gap_pct = 0;
  int unsigned shake_set    = SHAKE_RESET;
  int unsigned hold_set     = HOLD_RESET;
  int unsigned sent_total   = 0;
  int unsigned settings_run = 0;
  int unsigned quiet_cycles = 0;
  bit          hold_off_req = 1'b0;

  always #5 clk_i = ~clk_i;

  key_debounce_hold_detect_unit #(
    .NUM_KEYS(NumKeys)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_ch),
    .evt_o       (event_ch)
  );

  kdh_event_monitor #(
    .NUM_KEYS(NumKeys)
  ) u_event_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sample_i     (sample_ch),
    .evt_i        (event_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .pressed_o    (n_pressed),
    .released_o   (n_released),
    .held_o       (n_held)
  );

  // The run ends as a failure when no transfer happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (sample_ch.valid && sample_ch.ready) || (event_ch.valid && event_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("Timeout: no transfer for %0d cycles.", QuietLimit);
      $display("key_debounce_hold_detect_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    event_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        event_ch.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        event_ch.ready <= ($urandom_range(99) >= sink_gap_pct);
      end
    end
  end

  task automatic send_sample(input logic [KEY_W-1:0] key, input logic pin);
    if ($urandom_range(99) < src_gap_pct) begin
      sample_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_gap_pct);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.key_index <= key;
    sample_ch.pin_level <= pin;
    do @(posedge clk_i); while (!sample_ch.ready);
    sent_total++;
  endtask

  task automatic settle();
    sample_ch.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reconfigure(input int unsigned shake, input int unsigned hold);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SHAKE;
    cfg_wdata_i <= CFG_DAT_W'(shake);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_HOLD;
    cfg_wdata_i <= CFG_DAT_W'(hold);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shake_set = shake;
    hold_set  = hold;
    settings_run++;
  endtask

  // Runs of one level on one key, broken by bounces and by samples of random keys.
  task automatic drive_runs(input int unsigned n_items);
    int unsigned      left;
    int unsigned      run_len;
    int unsigned      span;
    int unsigned      roll;
    logic [KEY_W-1:0] focus;
    logic             level;
    left = n_items;
    span = ((shake_set == 0) ? 1 : shake_set) + ((hold_set == 0) ? 1 : hold_set) + 3;
    if (span > 130) span = 130;
    while (left != 0) begin
      focus   = KEY_W'($urandom_range(NumKeys - 1));
      level   = 1'($urandom_range(1));
      run_len = $urandom_range(span, 1);
      if (run_len > left) run_len = left;
      repeat (run_len) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          send_sample(KEY_W'($urandom_range(NumKeys - 1)), 1'($urandom_range(1)));
        end else if (roll < 14) begin
          send_sample(focus, ~level);
        end else begin
          send_sample(focus, level);
        end
      end
      left -= run_len;
    end
  endtask

  initial begin
    sample_ch.valid     = 1'b0;
    sample_ch.key_index = '0;
    sample_ch.pin_level = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Press, hold across a bounce, release; then a press broken by its own bounce.
    reconfigure(2, 3);
    send_sample(2'd0, 1'b0); send_sample(2'd0, 1'b0); send_sample(2'd0, 1'b0);
    send_sample(2'd0, 1'b0); send_sample(2'd0, 1'b1); send_sample(2'd0, 1'b0);
    send_sample(2'd0, 1'b0); send_sample(2'd0, 1'b1); send_sample(2'd0, 1'b1);
    send_sample(2'd1, 1'b0); send_sample(2'd1, 1'b1); send_sample(2'd1, 1'b0);
    send_sample(2'd2, 1'b0); send_sample(2'd1, 1'b0); send_sample(2'd2, 1'b0);
    send_sample(2'd3, 1'b1); send_sample(2'd3, 1'b0); send_sample(2'd3, 1'b0);
    send_sample(2'd1, 1'b1); send_sample(2'd1, 1'b1); send_sample(2'd3, 1'b1);

    src_gap_pct  = 12;
    sink_gap_pct = 77;
    reconfigure(SHAKE_RESET, HOLD_RESET);
    hold_off_req = 1'b1;
    drive_runs(200);
    reconfigure(1, 1);
    drive_runs(100);
    reconfigure(0, 0);
    drive_runs(100);
    reconfigure(2, 3);
    drive_runs(120);

    src_gap_pct  = 77;
    sink_gap_pct = 12;
    reconfigure(3, 7);
    drive_runs(120);
    reconfigure(CNT_MAX, CNT_MAX);
    drive_runs(60);
    // Counters built up under the large settings can sit above the new thresholds.
    reconfigure(2, 5);
    drive_runs(100);
    reconfigure(4, 12);
    drive_runs(120);

    src_gap_pct  = 0;
    sink_gap_pct = 0;
    reconfigure($urandom_range(6, 1), $urandom_range(30, 1));
    drive_runs(120);
    reconfigure(CNT_MAX, 1);
    drive_runs(60);
    reconfigure(1, CNT_MAX);
    drive_runs(80);
    reconfigure(SHAKE_RESET, HOLD_RESET);
    drive_runs(150);

    settle();
    $display("Sent %0d key samples under %0d register settings; %0d events checked.",
             sent_total, settings_run, checked);
    $display("Events seen: %0d pressed, %0d released, %0d held.", n_pressed, n_released, n_held);
    if (fail_count == 0 && pending == 0) begin
      $display("key_debounce_hold_detect_unit: match");
    end else begin
      $display("key_debounce_hold_detect_unit: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/kdh_pkg.sv
hdl/kdh_sample_if.sv
hdl/key_debounce_hold_detect_unit.sv
sim/kdh_event_monitor.sv
sim/testbench.sv
